FILE: rtl/core/bcrf_pkg.sv
// Package: widths, constants and payload types of the barometric climb-rate filter.
`default_nettype none

package bcrf_pkg;

	// Field widths
	localparam int PRES_W  = 25;
	localparam int TEMP_W  = 15;
	localparam int TIME_W  = 32;
	localparam int SCALE_W = 16;
	localparam int RATE_W  = 24;

	// History depth of the moving average
	localparam int AVG_DEPTH = 5;

	// Datapath widths
	localparam int MULT_W = 10;                       // width of the 625 factor
	localparam int SC_W   = SCALE_W + MULT_W;         // scale * 625
	localparam int TK_W   = 16;                       // temperature in centikelvin
	localparam int M1_W   = SC_W + PRES_W;            // scale * 625 * dP
	localparam int NUM_W  = M1_W + TK_W;              // full numerator
	localparam int DEN0_W = PRES_W + TIME_W;          // P * dt
	localparam int DEN_W  = DEN0_W + 4;               // 16 * P * dt
	localparam int QUO_W  = RATE_W;                   // quotient bits kept
	localparam int HI_W   = NUM_W - QUO_W;            // numerator bits above the quotient
	localparam int SUM_W  = RATE_W + $clog2(AVG_DEPTH);
	localparam int DREM_W = $clog2(AVG_DEPTH);

	// Step counter
	localparam int STEP_MAX = (SUM_W > PRES_W) ? SUM_W : PRES_W;
	localparam int CNT_W    = $clog2(STEP_MAX);

	// Constants
	localparam logic [SCALE_W-1:0]      SCALE_RESET  = 16'd7319;
	localparam logic [MULT_W-1:0]       SCALE_MULT   = 10'd625;
	localparam logic signed [TEMP_W+1:0] KELVIN_CENTI = 17'sd27315;
	localparam logic signed [RATE_W-1:0] RATE_MAX    = 24'sh7FFFFF;
	localparam logic signed [RATE_W-1:0] RATE_MIN    = 24'sh800000;

	// One history entry
	typedef logic signed [RATE_W-1:0] rate_t;

endpackage

`default_nettype wire

FILE: rtl/core/bcrf_in_if.sv
// Interface: sample channel (pressure, temperature, timestamp) with valid/ready.
`default_nettype none

interface bcrf_in_if;
	logic                                valid;
	logic                                ready;
	logic [bcrf_pkg::PRES_W-1:0]         pressure_q8;
	logic signed [bcrf_pkg::TEMP_W-1:0]  temperature_centi;
	logic [bcrf_pkg::TIME_W-1:0]         timestamp_ms;

	modport source (output valid, output pressure_q8, output temperature_centi,
		output timestamp_ms, input ready);
	modport sink (input valid, input pressure_q8, input temperature_centi,
		input timestamp_ms, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bcrf_out_if.sv
// Interface: result channel (mean climb rate, fault flag) with valid/ready.
`default_nettype none

interface bcrf_out_if;
	logic                        valid;
	logic                        ready;
	logic signed [bcrf_pkg::RATE_W-1:0] climb_rate_mm_s;
	logic                        rate_fault;

	modport source (output valid, output climb_rate_mm_s, output rate_fault, input ready);
	modport sink (input valid, input climb_rate_mm_s, input rate_fault, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/barometric_climb_rate_filter.sv
// Top level: bit-serial climb-rate computation and moving-average filter.
// A sample with nonzero pressure and nonzero interval passes, after its transfer,
// through two shift-add multipliers (scale*625*dP and P*dt, one multiplier bit per
// cycle), a third for the temperature factor, one overflow check, a restoring divider
// (one quotient bit per cycle), a history push and a bit-serial divide of the SUM_W
// bit sum by the history depth for the mean. A sample with zero pressure or zero
// interval skips the multiply and divide. No new sample is taken until the result is
// loaded into the output register, where it waits while the next sample is taken;
// scale_q is written through cfg_we/cfg_wdata and resets to 7319 (Q8.8).
`default_nettype none

module barometric_climb_rate_filter (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [bcrf_pkg::SCALE_W-1:0]      cfg_wdata,
	bcrf_in_if.sink                                samples,
	bcrf_out_if.source                             rates
);

	localparam int PRES_W  = bcrf_pkg::PRES_W;
	localparam int TIME_W  = bcrf_pkg::TIME_W;
	localparam int RATE_W  = bcrf_pkg::RATE_W;
	localparam int SC_W    = bcrf_pkg::SC_W;
	localparam int TK_W    = bcrf_pkg::TK_W;
	localparam int M1_W    = bcrf_pkg::M1_W;
	localparam int NUM_W   = bcrf_pkg::NUM_W;
	localparam int DEN0_W  = bcrf_pkg::DEN0_W;
	localparam int DEN_W   = bcrf_pkg::DEN_W;
	localparam int QUO_W   = bcrf_pkg::QUO_W;
	localparam int HI_W    = bcrf_pkg::HI_W;
	localparam int SUM_W   = bcrf_pkg::SUM_W;
	localparam int DREM_W  = bcrf_pkg::DREM_W;
	localparam int CNT_W   = bcrf_pkg::CNT_W;
	localparam int DEPTH   = bcrf_pkg::AVG_DEPTH;

	// Sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL_A = 3'd1;
	localparam logic [2:0] ST_MUL_B = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_PUSH  = 3'd5;
	localparam logic [2:0] ST_MEAN  = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	// Control and state registers
	logic [2:0]                      state_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [bcrf_pkg::SCALE_W-1:0]    scale_q;
	logic [PRES_W-1:0]               last_p_q;
	logic [TIME_W-1:0]               last_t_q;
	bcrf_pkg::rate_t                 hist_q [DEPTH];
	logic signed [SUM_W-1:0]         sum_q;
	logic                            out_valid_q;

	// Payload registers
	logic [SC_W-1:0]                 sc_q;
	logic [TIME_W-1:0]               dt_q;
	logic                            neg_q;
	logic                            fault_q;
	logic [M1_W-1:0]                 p1_q;
	logic [DEN0_W-1:0]               pd_q;
	logic [NUM_W-1:0]                pn_q;
	logic [DEN_W-1:0]                rem_q;
	logic [QUO_W-1:0]                q_q;
	logic                            ovf_q;
	logic                            msgn_q;
	logic [SUM_W-1:0]                md_q;
	logic [DREM_W-1:0]               mrem_q;
	logic signed [RATE_W-1:0]        out_rate_q;
	logic                            out_fault_q;

	// Combinational signals
	logic                            in_xfer;
	logic [TIME_W-1:0]               dt_now;
	logic                            fault_now;
	logic                            neg_now;
	logic [PRES_W-1:0]               dp_now;
	logic signed [bcrf_pkg::TEMP_W+1:0] tk_wide;
	logic [SC_W:0]                   sum1;
	logic [TIME_W:0]                 sumd;
	logic [M1_W:0]                   sumn;
	logic [DEN_W-1:0]                den;
	logic [HI_W-1:0]                 num_hi;
	logic [DEN_W:0]                  r2;
	logic [DEN_W:0]                  r2_diff;
	logic                            r2_ge;
	bcrf_pkg::rate_t                 rate_new;
	logic                            rate_big;
	logic signed [SUM_W-1:0]         sum_next;
	logic [SUM_W-1:0]                sum_abs;
	logic [DREM_W:0]                 mr2;
	logic                            mr2_ge;
	logic signed [RATE_W-1:0]        mean;
	logic                            out_load;

	assign in_xfer       = samples.valid && samples.ready;
	assign samples.ready = (state_q == ST_IDLE);

	// Sample front end: interval, pressure change and absolute temperature
	always_comb begin
		dt_now    = samples.timestamp_ms - last_t_q;
		fault_now = (dt_now == '0) || (samples.pressure_q8 == '0);
		neg_now   = last_p_q < samples.pressure_q8;
		dp_now    = neg_now ? samples.pressure_q8 - last_p_q : last_p_q - samples.pressure_q8;
		tk_wide   = {{2{samples.temperature_centi[bcrf_pkg::TEMP_W-1]}},
			samples.temperature_centi} + bcrf_pkg::KELVIN_CENTI;
	end

	// Shift-add multiplier steps, one multiplier bit per cycle
	always_comb begin
		sum1 = {1'b0, p1_q[M1_W-1:PRES_W]} + (p1_q[0] ? {1'b0, sc_q} : '0);
		sumd = {1'b0, pd_q[DEN0_W-1:PRES_W]} + (pd_q[0] ? {1'b0, dt_q} : '0);
		sumn = {1'b0, pn_q[NUM_W-1:TK_W]} + (pn_q[0] ? {1'b0, p1_q} : '0);
	end

	// Restoring divider step; the numerator's low bits leave pn_q from the top of its low part
	always_comb begin
		den     = {pd_q, 4'b0000};
		num_hi  = pn_q[NUM_W-1:QUO_W];
		r2      = {rem_q, pn_q[QUO_W-1]};
		r2_diff = r2 - {1'b0, den};
		r2_ge   = r2 >= {1'b0, den};
	end

	// Saturated rate and the new running sum
	always_comb begin
		rate_big = ovf_q || q_q[QUO_W-1];
		if (fault_q) begin
			rate_new = '0;
		end else if (neg_q) begin
			rate_new = rate_big ? bcrf_pkg::RATE_MIN : -$signed(q_q);
		end else begin
			rate_new = rate_big ? bcrf_pkg::RATE_MAX : $signed(q_q);
		end
		sum_next = sum_q
			+ {{(SUM_W-RATE_W){rate_new[RATE_W-1]}}, rate_new}
			- {{(SUM_W-RATE_W){hist_q[DEPTH-1][RATE_W-1]}}, hist_q[DEPTH-1]};
		sum_abs  = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
	end

	// Bit-serial divide of the sum by the depth
	always_comb begin
		mr2    = {mrem_q, md_q[SUM_W-1]};
		mr2_ge = mr2 >= (DREM_W+1)'(DEPTH);
		mean   = msgn_q ? -$signed(md_q[RATE_W-1:0]) : $signed(md_q[RATE_W-1:0]);
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rates.ready);

	// Sequencer, configuration, history and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			scale_q     <= bcrf_pkg::SCALE_RESET;
			last_p_q    <= '0;
			last_t_q    <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				scale_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rates.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						last_p_q <= samples.pressure_q8;
						last_t_q <= samples.timestamp_ms;
						state_q  <= fault_now ? ST_PUSH : ST_MUL_A;
						cnt_q    <= CNT_W'(PRES_W - 1);
					end
				end
				ST_MUL_A: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_MUL_B;
						cnt_q   <= CNT_W'(TK_W - 1);
					end
				end
				ST_MUL_B: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= ST_DIV;
					cnt_q   <= CNT_W'(QUO_W - 1);
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					hist_q[0] <= rate_new;
					for (int i = 1; i < DEPTH; i++) begin
						hist_q[i] <= hist_q[i-1];
					end
					sum_q   <= sum_next;
					state_q <= ST_MEAN;
					cnt_q   <= CNT_W'(SUM_W - 1);
				end
				ST_MEAN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath shift registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					sc_q    <= SC_W'(scale_q) * SC_W'(bcrf_pkg::SCALE_MULT);
					dt_q    <= dt_now;
					neg_q   <= neg_now;
					fault_q <= fault_now;
					p1_q    <= {(M1_W-PRES_W)'(0), dp_now};
					pd_q    <= {(DEN0_W-PRES_W)'(0), samples.pressure_q8};
					pn_q    <= {(NUM_W-TK_W)'(0), tk_wide[TK_W-1:0]};
					ovf_q   <= 1'b0;
					q_q     <= '0;
				end
			end
			ST_MUL_A: begin
				p1_q <= {sum1, p1_q[PRES_W-1:1]};
				pd_q <= {sumd, pd_q[PRES_W-1:1]};
			end
			ST_MUL_B: begin
				pn_q <= {sumn, pn_q[TK_W-1:1]};
			end
			ST_CHECK: begin
				// Quotient of 2^QUO_W or more saturates anyway
				ovf_q <= DEN_W'(num_hi) >= den;
				rem_q <= DEN_W'(num_hi);
			end
			ST_DIV: begin
				rem_q <= r2_ge ? r2_diff[DEN_W-1:0] : r2[DEN_W-1:0];
				q_q   <= {q_q[QUO_W-2:0], r2_ge};
				pn_q  <= pn_q << 1;
			end
			ST_PUSH: begin
				msgn_q <= sum_next[SUM_W-1];
				md_q   <= sum_abs;
				mrem_q <= '0;
			end
			ST_MEAN: begin
				mrem_q <= mr2_ge ? DREM_W'(mr2 - (DREM_W+1)'(DEPTH)) : mr2[DREM_W-1:0];
				md_q   <= {md_q[SUM_W-2:0], mr2_ge};
			end
			ST_DONE: begin
				if (out_load) begin
					out_rate_q  <= mean;
					out_fault_q <= fault_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rates.valid           = out_valid_q;
	assign rates.climb_rate_mm_s = out_rate_q;
	assign rates.rate_fault      = out_fault_q;

	// Faulted samples bypass the multiply and divide
	a_fault_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && fault_now) |=> (state_q == ST_PUSH))
		else $error("faulted sample did not go straight to the history push");

	// A new result appears only out of the final state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rates.valid) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside the final state");

	// Divider remainder stays below the divisor unless the quotient already saturated
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !ovf_q) |-> (rem_q < den))
		else $error("divider remainder out of range");

	// Mean divider remainder stays below the depth
	a_mean_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MEAN) |-> (mrem_q < DREM_W'(DEPTH)))
		else $error("mean remainder out of range");

	// Leaving the final state always presents a result and frees the input
	a_done_exit: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (rates.valid && state_q == ST_IDLE))
		else $error("result not presented after completion");

endmodule

`default_nettype wire
